// ===== hw/rtl/gvk_pkg.sv =====
// shared widths, sideband types and latency of the gravity kick pipeline
package gvk_pkg;

	localparam int POS_W   = 32;
	localparam int DT_W    = 16;
	localparam int DIFF_W  = POS_W + 1;          // exact position difference
	localparam int RAD_W   = 2 * DIFF_W;         // squared distance
	localparam int DIST_W  = RAD_W / 2;          // integer square root
	localparam int SQ_REM_W = DIST_W + 2;
	localparam int GM_W    = 2 * POS_W;
	localparam int K_W     = GM_W + DT_W;        // G * m * dt
	localparam int NUM_W   = K_W + DIFF_W;       // K * |delta|
	localparam int DEN_W   = 3 * DIST_W;         // d^3
	localparam int QUO_W   = 38;                 // quotient bits kept before the clamp
	localparam int KCH_W   = 27;                 // K split into three chunks
	localparam int PP_W    = KCH_W + DIFF_W;
	localparam int MAG_W   = QUO_W - 4;
	localparam int SUM_W   = MAG_W + 2;

	localparam logic [MAG_W-1:0] KICK_MAX = MAG_W'(64'h2_0000_0000);

	// cycles from an accepted start to the done strobe
	localparam int LATENCY = 78;

	typedef struct packed {
		logic signed [POS_W-1:0] vel_x;
		logic signed [POS_W-1:0] vel_y;
		logic                    neg_x;
		logic                    neg_y;
		logic                    coinc;
	} kick_side_t;

	typedef struct packed {
		kick_side_t        kick;
		logic [DIFF_W-1:0] mag_x;
		logic [DIFF_W-1:0] mag_y;
		logic [K_W-1:0]    k;
	} root_side_t;

endpackage

// ===== hw/rtl/gvk_sqrt.sv =====
// pipelined integer square root, one root bit per stage
module gvk_sqrt import gvk_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [RAD_W-1:0]  radicand,
	input  root_side_t        in_side,
	output logic              out_valid,
	output logic [DIST_W-1:0] root,
	output root_side_t        out_side
);

	logic                vld_q  [DIST_W];
	logic [RAD_W-1:0]    rad_q  [DIST_W];
	logic [SQ_REM_W-1:0] rem_q  [DIST_W];
	logic [DIST_W-1:0]   root_q [DIST_W];
	root_side_t          side_q [DIST_W];

	for (genvar j = 0; j < DIST_W; j++) begin : g_step
		logic                v_in;
		logic [RAD_W-1:0]    rad_in;
		logic [SQ_REM_W-1:0] rem_in;
		logic [DIST_W-1:0]   root_in;
		root_side_t          side_in;
		logic [SQ_REM_W+1:0] acc;
		logic [SQ_REM_W+1:0] trial;
		logic [SQ_REM_W+1:0] diff;
		logic                take;

		if (j == 0) begin : g_first
			assign v_in    = in_valid;
			assign rad_in  = radicand;
			assign rem_in  = '0;
			assign root_in = '0;
			assign side_in = in_side;
		end else begin : g_next
			assign v_in    = vld_q[j-1];
			assign rad_in  = rad_q[j-1];
			assign rem_in  = rem_q[j-1];
			assign root_in = root_q[j-1];
			assign side_in = side_q[j-1];
		end

		// bring down the next two radicand bits and try (4*root + 1)
		assign acc   = {rem_in, rad_in[RAD_W-1 -: 2]};
		assign trial = {1'b0, root_in, 2'b01};
		assign diff  = acc - trial;
		assign take  = (acc >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[j] <= 1'b0;
			end else begin
				vld_q[j] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			rad_q[j]  <= {rad_in[RAD_W-3:0], 2'b00};
			rem_q[j]  <= take ? diff[SQ_REM_W-1:0] : acc[SQ_REM_W-1:0];
			root_q[j] <= {root_in[DIST_W-2:0], take};
			side_q[j] <= side_in;
		end
	end

	assign out_valid = vld_q[DIST_W-1];
	assign root      = root_q[DIST_W-1];
	assign out_side  = side_q[DIST_W-1];

endmodule

// ===== hw/rtl/gvk_div.sv =====
// two-lane pipelined restoring divider sharing one divisor, one quotient bit per stage
module gvk_div import gvk_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [NUM_W-1:0] num_x,
	input  logic [NUM_W-1:0] num_y,
	input  logic [DEN_W-1:0] den,
	input  kick_side_t       in_side,
	output logic             out_valid,
	output logic [QUO_W-1:0] quo_x,
	output logic [QUO_W-1:0] quo_y,
	output logic             ovf_x,
	output logic             ovf_y,
	output kick_side_t       out_side
);

	localparam int HEAD_W = NUM_W - QUO_W;

	logic             vld_q  [QUO_W];
	logic [DEN_W-1:0] den_q  [QUO_W];
	kick_side_t       side_q [QUO_W];
	logic [DEN_W-1:0] rem_q  [QUO_W][2];
	logic [QUO_W-1:0] low_q  [QUO_W][2];
	logic [QUO_W-1:0] quo_q  [QUO_W][2];
	logic             ovf_q  [QUO_W][2];

	logic [NUM_W-1:0] num_in [2];
	assign num_in[0] = num_x;
	assign num_in[1] = num_y;

	for (genvar j = 0; j < QUO_W; j++) begin : g_step
		logic             v_in;
		logic [DEN_W-1:0] den_in;
		kick_side_t       side_in;

		if (j == 0) begin : g_first
			assign v_in    = in_valid;
			assign den_in  = den;
			assign side_in = in_side;
		end else begin : g_next
			assign v_in    = vld_q[j-1];
			assign den_in  = den_q[j-1];
			assign side_in = side_q[j-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[j] <= 1'b0;
			end else begin
				vld_q[j] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			den_q[j]  <= den_in;
			side_q[j] <= side_in;
		end

		for (genvar l = 0; l < 2; l++) begin : g_lane
			logic [DEN_W-1:0] rem_in;
			logic [QUO_W-1:0] low_in;
			logic [QUO_W-1:0] quo_in;
			logic             ovf_in;
			logic [DEN_W:0]   acc;
			logic [DEN_W:0]   diff;
			logic             take;

			if (j == 0) begin : g_first
				// quotient above QUO_W bits means the kick is clamped anyway
				assign rem_in = {{(DEN_W-HEAD_W){1'b0}}, num_in[l][NUM_W-1:QUO_W]};
				assign low_in = num_in[l][QUO_W-1:0];
				assign quo_in = '0;
				assign ovf_in = (rem_in >= den);
			end else begin : g_next
				assign rem_in = rem_q[j-1][l];
				assign low_in = low_q[j-1][l];
				assign quo_in = quo_q[j-1][l];
				assign ovf_in = ovf_q[j-1][l];
			end

			assign acc  = {rem_in, low_in[QUO_W-1]};
			assign diff = acc - {1'b0, den_in};
			assign take = (acc >= {1'b0, den_in});

			always_ff @(posedge clk) begin
				rem_q[j][l] <= take ? diff[DEN_W-1:0] : acc[DEN_W-1:0];
				low_q[j][l] <= {low_in[QUO_W-2:0], 1'b0};
				quo_q[j][l] <= {quo_in[QUO_W-2:0], take};
				ovf_q[j][l] <= ovf_in;
			end
		end
	end

	assign out_valid = vld_q[QUO_W-1];
	assign out_side  = side_q[QUO_W-1];
	assign quo_x     = quo_q[QUO_W-1][0];
	assign quo_y     = quo_q[QUO_W-1][1];
	assign ovf_x     = ovf_q[QUO_W-1][0];
	assign ovf_y     = ovf_q[QUO_W-1][1];

endmodule

// ===== hw/rtl/pairwise_gravity_velocity_kick.sv =====
// top level: 2-D pairwise gravity velocity kick, fully pipelined
//
// Takes one body pair in every cycle: busy is low except in the first cycle after reset, and
// the result comes out with done high once the pair has passed every stage, in the order the
// pairs went in. The latency is set by the square root (one root bit per stage, 33 stages) and
// the divide by d^3 (one quotient bit per stage, 38 stages) plus seven stages of subtract,
// multiply and saturate. The receiver cannot stall; every result is shown for one cycle only.
// grav_const is written through cfg_valid/cfg_ready (always ready) and must not change while
// pairs are in flight.
module pairwise_gravity_velocity_kick import gvk_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [POS_W-1:0]        grav_const,
	input  logic                    start,
	output logic                    busy,
	input  logic signed [POS_W-1:0] src_pos_x,
	input  logic signed [POS_W-1:0] src_pos_y,
	input  logic [POS_W-1:0]        src_mass,
	input  logic signed [POS_W-1:0] tgt_pos_x,
	input  logic signed [POS_W-1:0] tgt_pos_y,
	input  logic signed [POS_W-1:0] tgt_vel_x,
	input  logic signed [POS_W-1:0] tgt_vel_y,
	input  logic [DT_W-1:0]         time_step,
	output logic                    done,
	output logic signed [POS_W-1:0] new_vel_x,
	output logic signed [POS_W-1:0] new_vel_y,
	output logic                    coincident,
	output logic                    saturated
);

	logic [POS_W-1:0] grav_q;
	logic             busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grav_q <= POS_W'(32'h0100_0000);
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				grav_q <= grav_const;
			end
		end
	end

	assign cfg_ready = 1'b1;
	assign busy      = busy_q;

	// stage 1: differences, magnitudes, G*m
	logic signed [DIFF_W-1:0] dx, dy;
	logic [DIFF_W-1:0]        mx, my;

	assign dx = {src_pos_x[POS_W-1], src_pos_x} - {tgt_pos_x[POS_W-1], tgt_pos_x};
	assign dy = {src_pos_y[POS_W-1], src_pos_y} - {tgt_pos_y[POS_W-1], tgt_pos_y};
	assign mx = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
	assign my = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);

	logic              vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic [DIFF_W-1:0] mx_s1, my_s1, mx_s2, my_s2;
	logic [GM_W-1:0]   gm_s1;
	logic [DT_W-1:0]   dt_s1;
	kick_side_t        kick_s1, kick_s2;

	always_ff @(posedge clk) begin
		mx_s1         <= mx;
		my_s1         <= my;
		gm_s1         <= GM_W'(grav_q * src_mass);
		dt_s1         <= time_step;
		kick_s1.vel_x <= tgt_vel_x;
		kick_s1.vel_y <= tgt_vel_y;
		kick_s1.neg_x <= dx[DIFF_W-1];
		kick_s1.neg_y <= dy[DIFF_W-1];
		kick_s1.coinc <= (dx == '0) && (dy == '0);
	end

	// stage 2: squares and K = G*m*dt
	logic [RAD_W-1:0] sqx_s2, sqy_s2, d2_s3;
	logic [K_W-1:0]   k_s2;
	root_side_t       side_s3;

	always_ff @(posedge clk) begin
		sqx_s2  <= RAD_W'(mx_s1 * mx_s1);
		sqy_s2  <= RAD_W'(my_s1 * my_s1);
		k_s2    <= K_W'(gm_s1 * dt_s1);
		mx_s2   <= mx_s1;
		my_s2   <= my_s1;
		kick_s2 <= kick_s1;
	end

	// stage 3: squared distance
	always_ff @(posedge clk) begin
		d2_s3         <= sqx_s2 + sqy_s2;
		side_s3.kick  <= kick_s2;
		side_s3.mag_x <= mx_s2;
		side_s3.mag_y <= my_s2;
		side_s3.k     <= k_s2;
	end

	logic              vld_r;
	logic [DIST_W-1:0] d_r;
	root_side_t        side_r;

	gvk_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s3),
		.radicand  (d2_s3),
		.in_side   (side_s3),
		.out_valid (vld_r),
		.root      (d_r),
		.out_side  (side_r)
	);

	// stage 4: d^2 and partial products of K*|delta|
	logic [KCH_W-1:0]  kch [3];
	assign kch[0] = side_r.k[KCH_W-1:0];
	assign kch[1] = side_r.k[2*KCH_W-1:KCH_W];
	assign kch[2] = {{(3*KCH_W-K_W){1'b0}}, side_r.k[K_W-1:2*KCH_W]};

	logic [RAD_W-1:0]  dd_s4;
	logic [DIST_W-1:0] d_s4;
	logic [PP_W-1:0]   ppx_s4 [3];
	logic [PP_W-1:0]   ppy_s4 [3];
	kick_side_t        kick_s4, kick_s5, kick_s6;

	always_ff @(posedge clk) begin
		dd_s4   <= RAD_W'(d_r * d_r);
		d_s4    <= d_r;
		kick_s4 <= side_r.kick;
		for (int c = 0; c < 3; c++) begin
			ppx_s4[c] <= PP_W'(kch[c] * side_r.mag_x);
			ppy_s4[c] <= PP_W'(kch[c] * side_r.mag_y);
		end
	end

	// stage 5: d^3 halves, numerators
	logic [NUM_W:0]      nx_sum, ny_sum;
	logic [2*DIST_W-1:0] dlo_s5, dhi_s5;
	logic [NUM_W-1:0]    nx_s5, ny_s5, nx_s6, ny_s6;
	logic [DEN_W-1:0]    den_s6;
	logic [DEN_W:0]      den_sum;

	assign nx_sum = (NUM_W+1)'(ppx_s4[0]) + ((NUM_W+1)'(ppx_s4[1]) << KCH_W)
		+ ((NUM_W+1)'(ppx_s4[2]) << (2*KCH_W));
	assign ny_sum = (NUM_W+1)'(ppy_s4[0]) + ((NUM_W+1)'(ppy_s4[1]) << KCH_W)
		+ ((NUM_W+1)'(ppy_s4[2]) << (2*KCH_W));

	always_ff @(posedge clk) begin
		dlo_s5  <= (2*DIST_W)'(dd_s4[DIST_W-1:0] * d_s4);
		dhi_s5  <= (2*DIST_W)'(dd_s4[RAD_W-1:DIST_W] * d_s4);
		nx_s5   <= nx_sum[NUM_W-1:0];
		ny_s5   <= ny_sum[NUM_W-1:0];
		kick_s5 <= kick_s4;
	end

	// stage 6: d^3
	assign den_sum = (DEN_W+1)'(dlo_s5) + ((DEN_W+1)'(dhi_s5) << DIST_W);

	always_ff @(posedge clk) begin
		den_s6  <= den_sum[DEN_W-1:0];
		nx_s6   <= nx_s5;
		ny_s6   <= ny_s5;
		kick_s6 <= kick_s5;
	end

	logic             vld_dv, ovfx_dv, ovfy_dv;
	logic [QUO_W-1:0] qx_dv, qy_dv;
	kick_side_t       kick_dv;

	gvk_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s6),
		.num_x     (nx_s6),
		.num_y     (ny_s6),
		.den       (den_s6),
		.in_side   (kick_s6),
		.out_valid (vld_dv),
		.quo_x     (qx_dv),
		.quo_y     (qy_dv),
		.ovf_x     (ovfx_dv),
		.ovf_y     (ovfy_dv),
		.out_side  (kick_dv)
	);

	// stage 7: scale, clamp kick, add to velocity and saturate
	typedef struct packed {
		logic [POS_W-1:0] vel;
		logic             sat;
	} vel_res_t;

	function automatic vel_res_t apply_kick(logic signed [POS_W-1:0] vel,
			logic [QUO_W-1:0] quo, logic ovf, logic neg);
		logic [MAG_W-1:0]        mag;
		logic signed [SUM_W-1:0] dv;
		logic signed [SUM_W-1:0] sum;
		vel_res_t                res;
		mag = quo[QUO_W-1:QUO_W-MAG_W];
		if (ovf || (mag > KICK_MAX)) begin
			mag = KICK_MAX;
		end
		dv  = neg ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
		sum = SUM_W'(vel) + dv;
		res.sat = 1'b0;
		if (sum > SUM_W'(signed'(32'sh7FFF_FFFF))) begin
			res.vel = 32'h7FFF_FFFF;
			res.sat = 1'b1;
		end else if (sum < SUM_W'(signed'(32'sh8000_0000))) begin
			res.vel = 32'h8000_0000;
			res.sat = 1'b1;
		end else begin
			res.vel = sum[POS_W-1:0];
		end
		return res;
	endfunction

	vel_res_t res_x, res_y;
	assign res_x = apply_kick(kick_dv.vel_x, qx_dv, ovfx_dv, kick_dv.neg_x);
	assign res_y = apply_kick(kick_dv.vel_y, qy_dv, ovfy_dv, kick_dv.neg_y);

	logic signed [POS_W-1:0] velx_s7, vely_s7;
	logic                    coinc_s7, sat_s7;

	always_ff @(posedge clk) begin
		if (kick_dv.coinc) begin
			velx_s7 <= kick_dv.vel_x;
			vely_s7 <= kick_dv.vel_y;
			sat_s7  <= 1'b0;
		end else begin
			velx_s7 <= res_x.vel;
			vely_s7 <= res_y.vel;
			sat_s7  <= res_x.sat || res_y.sat;
		end
		coinc_s7 <= kick_dv.coinc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy_q;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_r;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_dv;
		end
	end

	assign done       = vld_s7;
	assign new_vel_x  = velx_s7;
	assign new_vel_y  = vely_s7;
	assign coincident = coinc_s7;
	assign saturated  = sat_s7;

endmodule

// ===== hw/rtl/gvk_checker.sv =====
// port-level checker for the gravity kick block, bound to the top level
module gvk_checker import gvk_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    cfg_valid,
	input logic                    cfg_ready,
	input logic [POS_W-1:0]        grav_const,
	input logic                    start,
	input logic                    busy,
	input logic signed [POS_W-1:0] src_pos_x,
	input logic signed [POS_W-1:0] src_pos_y,
	input logic [POS_W-1:0]        src_mass,
	input logic signed [POS_W-1:0] tgt_pos_x,
	input logic signed [POS_W-1:0] tgt_pos_y,
	input logic signed [POS_W-1:0] tgt_vel_x,
	input logic signed [POS_W-1:0] tgt_vel_y,
	input logic [DT_W-1:0]         time_step,
	input logic                    done,
	input logic signed [POS_W-1:0] new_vel_x,
	input logic signed [POS_W-1:0] new_vel_y,
	input logic                    coincident,
	input logic                    saturated
);

	logic take;
	assign take = start && !busy;

	// every transfer in gives a result at the fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> ##LATENCY done)
		else $error("result missing at fixed latency");

	// coincident pairs pass the velocity through
	a_coinc_pass: assert property (@(posedge clk) disable iff (!arst_n)
		take && (src_pos_x == tgt_pos_x) && (src_pos_y == tgt_pos_y)
		|-> ##LATENCY (coincident && new_vel_x == $past(tgt_vel_x, LATENCY)
			&& new_vel_y == $past(tgt_vel_y, LATENCY)))
		else $error("coincident pair did not pass velocity unchanged");

	a_coinc_nosat: assert property (@(posedge clk) disable iff (!arst_n)
		done && coincident |-> !saturated)
		else $error("saturated flagged on coincident pair");

endmodule

bind pairwise_gravity_velocity_kick gvk_checker u_gvk_checker (.*);
